### rtl/cfa_pkg.sv
// Package for the contiguous fit allocator.
// Holds field widths, status and policy codes, the map entry type and the
// sequencer state type. No dependencies.
package cfa_pkg;

  localparam int MODE_W   = 1;
  localparam int SIZE_W   = 7;
  localparam int ADDR_W   = 6;
  localparam int STATUS_W = 2;
  localparam int POLICY_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOBLK = 2'd2;

  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;

  typedef struct packed {
    logic used;
    logic start;
  } map_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_SCAN,
    ST_A_WRITE,
    ST_F_CHECK,
    ST_F_WALK,
    ST_RESP
  } seq_state_t;

endpackage

### rtl/cfa_if.sv
// Request and response channel interfaces for the allocator.
// Depends on cfa_pkg for the field widths.
interface cfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [cfa_pkg::MODE_W-1:0]    mode;
  logic [cfa_pkg::SIZE_W-1:0]    alloc_size;
  logic [cfa_pkg::ADDR_W-1:0]    block_address;

  modport source (output valid, output mode, output alloc_size, output block_address,
                  input ready);
  modport sink (input valid, input mode, input alloc_size, input block_address,
                output ready);
endinterface

interface cfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cfa_pkg::STATUS_W-1:0]  status_code;
  logic [cfa_pkg::ADDR_W-1:0]    start_address;

  modport source (output valid, output status_code, output start_address, input ready);
  modport sink (input valid, input status_code, input start_address, output ready);
endinterface

### rtl/cfa_map_ram.sv
// Map memory: one used bit and one block-start bit per store unit.
// One write port and one registered read port. Depends on cfa_pkg.
module cfa_map_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  cfa_pkg::map_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output cfa_pkg::map_entry_t rdata
);
  import cfa_pkg::*;

  map_entry_t mem [DEPTH];
  map_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/cfa_seq.sv
// Sequencer of the allocator: clearing pass, hole scan, block write and free walk.
// Reads and writes the map memory one unit per cycle. Depends on cfa_pkg.
module cfa_seq #(
  parameter int MEM_UNITS = 64,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [cfa_pkg::POLICY_W-1:0]    fit_policy,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [cfa_pkg::MODE_W-1:0]      req_mode,
  input  logic [cfa_pkg::SIZE_W-1:0]      req_size,
  input  logic [cfa_pkg::ADDR_W-1:0]      req_addr,
  input  logic                            res_ready,
  output logic                            res_load,
  output logic [cfa_pkg::STATUS_W-1:0]    res_status,
  output logic [cfa_pkg::ADDR_W-1:0]      res_addr,
  output logic                            mem_we,
  output logic [AW-1:0]                   mem_waddr,
  output cfa_pkg::map_entry_t             mem_wdata,
  output logic [AW-1:0]                   mem_raddr,
  input  cfa_pkg::map_entry_t             mem_rdata
);
  import cfa_pkg::*;

  seq_state_t            state_r, state_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         run_start_r, run_start_nxt;
  logic [CW-1:0]         run_len_r, run_len_nxt;
  logic [AW-1:0]         best_at_r, best_at_nxt;
  logic [CW-1:0]         best_len_r, best_len_nxt;
  logic                  found_r, found_nxt;
  logic [CW-1:0]         wr_cnt_r, wr_cnt_nxt;
  logic [CW-1:0]         size_r, size_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;

  logic                  last;
  logic                  unit_free;
  logic [CW-1:0]         cur_len;
  logic [AW-1:0]         cur_start;
  logic                  run_end;
  logic                  take;
  logic [CW-1:0]         in_addr_cw;
  logic [CW-1:0]         in_size_cw;

  assign last       = (idx_r == AW'(MEM_UNITS - 1));
  assign unit_free  = !mem_rdata.used;
  assign cur_len    = unit_free ? run_len_r + CW'(1) : run_len_r;
  assign cur_start  = (unit_free && run_len_r == '0) ? idx_r : run_start_r;
  assign run_end    = !unit_free || last;
  assign take       = run_end && (cur_len >= size_r) &&
                      (!found_r ||
                       (fit_policy == POLICY_BEST && cur_len < best_len_r) ||
                       (fit_policy != POLICY_FIRST && fit_policy != POLICY_BEST &&
                        cur_len > best_len_r));
  assign in_addr_cw = CW'(req_addr);
  assign in_size_cw = CW'(req_size);

  assign res_status = status_r;
  assign res_addr   = out_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_start_r <= run_start_nxt;
    run_len_r   <= run_len_nxt;
    best_at_r   <= best_at_nxt;
    best_len_r  <= best_len_nxt;
    found_r     <= found_nxt;
    wr_cnt_r    <= wr_cnt_nxt;
    size_r      <= size_nxt;
    addr_r      <= addr_nxt;
    status_r    <= status_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    best_at_nxt   = best_at_r;
    best_len_nxt  = best_len_r;
    found_nxt     = found_r;
    wr_cnt_nxt    = wr_cnt_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    status_nxt    = status_r;
    out_addr_nxt  = out_addr_r;
    req_ready     = 1'b0;
    res_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '0;
    mem_raddr     = last ? idx_r : idx_r + AW'(1);

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (last) begin
          state_nxt = ST_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        mem_raddr = (req_mode == MODE_FREE) ? AW'(in_addr_cw) : '0;
        if (req_valid) begin
          size_nxt     = in_size_cw;
          addr_nxt     = req_addr;
          run_len_nxt  = '0;
          run_start_nxt = '0;
          found_nxt    = 1'b0;
          best_len_nxt = '0;
          best_at_nxt  = '0;
          wr_cnt_nxt   = '0;
          if (req_mode == MODE_FREE) begin
            idx_nxt = AW'(in_addr_cw);
            if (in_addr_cw >= CW'(MEM_UNITS)) begin
              status_nxt   = STATUS_NOBLK;
              out_addr_nxt = req_addr;
              state_nxt    = ST_RESP;
            end else begin
              state_nxt = ST_F_CHECK;
            end
          end else begin
            idx_nxt = '0;
            if (in_size_cw == '0 || in_size_cw > CW'(MEM_UNITS)) begin
              status_nxt   = STATUS_NOFIT;
              out_addr_nxt = '0;
              state_nxt    = ST_RESP;
            end else begin
              state_nxt = ST_A_SCAN;
            end
          end
        end
      end
      ST_A_SCAN: begin
        run_start_nxt = cur_start;
        run_len_nxt   = run_end ? '0 : cur_len;
        if (take) begin
          best_at_nxt  = cur_start;
          best_len_nxt = cur_len;
          found_nxt    = 1'b1;
        end
        if (last) begin
          if (take || found_r) begin
            idx_nxt    = take ? cur_start : best_at_r;
            wr_cnt_nxt = '0;
            state_nxt  = ST_A_WRITE;
          end else begin
            status_nxt   = STATUS_NOFIT;
            out_addr_nxt = '0;
            state_nxt    = ST_RESP;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_A_WRITE: begin
        mem_we          = 1'b1;
        mem_wdata.used  = 1'b1;
        mem_wdata.start = (wr_cnt_r == '0);
        if (wr_cnt_r + CW'(1) == size_r) begin
          status_nxt   = STATUS_OK;
          out_addr_nxt = ADDR_W'(CW'(best_at_r));
          state_nxt    = ST_RESP;
        end else begin
          idx_nxt    = idx_r + AW'(1);
          wr_cnt_nxt = wr_cnt_r + CW'(1);
        end
      end
      ST_F_CHECK: begin
        out_addr_nxt = addr_r;
        if (!(mem_rdata.used && mem_rdata.start)) begin
          status_nxt = STATUS_NOBLK;
          state_nxt  = ST_RESP;
        end else begin
          mem_we     = 1'b1;
          status_nxt = STATUS_OK;
          if (last) begin
            state_nxt = ST_RESP;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_F_WALK;
          end
        end
      end
      ST_F_WALK: begin
        if (mem_rdata.used && !mem_rdata.start) begin
          mem_we = 1'b1;
          if (last) begin
            state_nxt = ST_RESP;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/contiguous_fit_allocator_top.sv
// Top level of the contiguous fit allocator: policy register, sequencer,
// map memory and result register. Depends on cfa_pkg, cfa_if, cfa_seq, cfa_map_ram.

// The allocator keeps one used bit and one block-start bit per unit in a
// single-port-read memory and walks it one unit per cycle. After reset a
// clearing pass over all units runs before the first request is taken.
// An allocation runs a full scan, then one write per unit of the block, or
// ends after the scan when no hole fits; a rejected size goes straight to
// the response. A free checks the start unit, then clears it and each
// following unit of the freed block. The single memory read port, read once
// per cycle, paces these steps. The finished result sits in an output
// register, so the next request is taken while it waits.
module contiguous_fit_allocator_top #(
  parameter int MEM_UNITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cfa_req_if.sink                      in_chan,
  cfa_rsp_if.source                    out_chan,
  input  logic                         cfg_we,
  input  logic [cfa_pkg::POLICY_W-1:0] cfg_wdata
);
  import cfa_pkg::*;

  localparam int AW  = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int LW  = $clog2(MEM_UNITS + 1);
  localparam int CW  = (LW > SIZE_W) ? LW : SIZE_W;

  logic [POLICY_W-1:0] fit_policy_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;

  logic                res_ready;
  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  map_entry_t          mem_wdata;
  logic [AW-1:0]       mem_raddr;
  map_entry_t          mem_rdata;

  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POLICY_FIRST;
    end else if (cfg_we) begin
      fit_policy_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status_code   = out_status_r;
  assign out_chan.start_address = out_addr_r;

  cfa_seq #(
    .MEM_UNITS (MEM_UNITS),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fit_policy (fit_policy_r),
    .req_valid  (in_chan.valid),
    .req_ready  (in_chan.ready),
    .req_mode   (in_chan.mode),
    .req_size   (in_chan.alloc_size),
    .req_addr   (in_chan.block_address),
    .res_ready  (res_ready),
    .res_load   (res_load),
    .res_status (res_status),
    .res_addr   (res_addr),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  cfa_map_ram #(
    .DEPTH (MEM_UNITS),
    .AW    (AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### rtl/cfa_checker.sv
// Port-level checker for the allocator and its bind to the top level.
// Depends on cfa_pkg and contiguous_fit_allocator_top.
module cfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cfa_pkg::STATUS_W-1:0] out_status,
  input logic [cfa_pkg::ADDR_W-1:0]   out_addr
);
  import cfa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_addr))
    else $error("Stalled result changed.");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_NOFIT ||
                   out_status == STATUS_NOBLK))
    else $error("Undefined status code.");

  a_nofit_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_NOFIT |-> out_addr == '0)
    else $error("Failed allocation returned a nonzero address.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A request was taken in the cycle after another.");

endmodule

bind contiguous_fit_allocator_top cfa_checker u_cfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status_code),
  .out_addr   (out_chan.start_address)
);

### bench/contiguous_fit_allocator_top_test.sv
`timescale 1ns / 100ps
// Self-checking test of the contiguous fit allocator under all fit policies.
// Keeps a shadow of the used and block-start maps to predict every response.
// Depends on cfa_pkg, cfa_if and contiguous_fit_allocator_top.
module contiguous_fit_allocator_top_test;
  import cfa_pkg::*;

  localparam int MEM_UNITS = 64;
  localparam int PHASE_ITEMS = 152;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;
  localparam logic [POLICY_W-1:0] POLICY_WORST_ALT = 2'd3;
  localparam logic [POLICY_W-1:0] PHASE_POLICY [4] = '{POLICY_FIRST, POLICY_BEST,
                                                      POLICY_WORST, POLICY_WORST_ALT};
  localparam int SEND_IDLE [3] = '{13, 83, 0};
  localparam int RECV_IDLE [3] = '{83, 13, 0};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] block_address;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address;
  } outcome_t;

  class store_shadow;
    bit [MEM_UNITS-1:0] used;
    bit [MEM_UNITS-1:0] starts;
    logic [POLICY_W-1:0] policy;
    outcome_t pending_outcomes[$];
    int errors;

    function new();
      used = '0;
      starts = '0;
      policy = POLICY_FIRST;
      errors = 0;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function outcome_t place_block(input int size);
      outcome_t o;
      int i;
      int j;
      int k;
      int hole;
      int pick;
      int pick_len;
      bit found;
      o.status = STATUS_NOFIT;
      o.address = '0;
      if (size == 0 || size > MEM_UNITS) return o;
      found = 1'b0;
      pick = 0;
      pick_len = 0;
      i = 0;
      while (i < MEM_UNITS) begin
        if (used[i]) begin
          i++;
          continue;
        end
        j = i;
        while (j < MEM_UNITS && !used[j]) j++;
        hole = j - i;
        if (hole >= size) begin
          if (!found) begin
            found = 1'b1;
            pick = i;
            pick_len = hole;
            if (policy == POLICY_FIRST) break;
          end else if (policy == POLICY_BEST) begin
            if (hole < pick_len) begin
              pick = i;
              pick_len = hole;
            end
          end else if (hole > pick_len) begin
            pick = i;
            pick_len = hole;
          end
        end
        i = j;
      end
      if (!found) return o;
      for (k = 0; k < size; k++) used[pick + k] = 1'b1;
      starts[pick] = 1'b1;
      o.status = STATUS_OK;
      o.address = pick[ADDR_W-1:0];
      return o;
    endfunction

    function outcome_t release_block(input logic [ADDR_W-1:0] addr);
      outcome_t o;
      int k;
      o.status = STATUS_NOBLK;
      o.address = addr;
      if (int'(addr) >= MEM_UNITS || !starts[addr] || !used[addr]) return o;
      starts[addr] = 1'b0;
      used[addr] = 1'b0;
      k = int'(addr) + 1;
      while (k < MEM_UNITS && used[k] && !starts[k]) begin
        used[k] = 1'b0;
        k++;
      end
      o.status = STATUS_OK;
      return o;
    endfunction

    function void note_request(input request_t r);
      if (r.mode == MODE_FREE) pending_outcomes.push_back(release_block(r.block_address));
      else pending_outcomes.push_back(place_block(int'(r.alloc_size)));
    endfunction

    function void check_response(input logic [STATUS_W-1:0] status,
                                 input logic [ADDR_W-1:0] address);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("response with no request outstanding: status_code %0d start_address %0d",
               status, address);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (status !== want.status) begin
        $error("status_code mismatch: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (address !== want.address) begin
        $error("start_address mismatch: expected %0d, actual %0d", want.address, address);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [POLICY_W-1:0] cfg_wdata;
  int send_idle_pct;
  int recv_idle_pct;
  store_shadow shadow = new();

  cfa_req_if request_chan();
  cfa_rsp_if result_chan();

  contiguous_fit_allocator_top #(
    .MEM_UNITS(MEM_UNITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (request_chan),
    .out_chan (result_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && result_chan.valid && result_chan.ready) begin
      shadow.check_response(result_chan.status_code, result_chan.start_address);
    end
    result_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr);
    request_t r;
    r.mode = mode;
    r.alloc_size = size;
    r.block_address = addr;
    while ($urandom_range(99) < send_idle_pct) begin
      request_chan.valid <= 1'b0;
      @(posedge clk);
    end
    request_chan.valid <= 1'b1;
    request_chan.mode <= mode;
    request_chan.alloc_size <= size;
    request_chan.block_address <= addr;
    do @(posedge clk); while (!request_chan.ready);
    shadow.note_request(r);
  endtask

  task automatic drain_results();
    request_chan.valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  task automatic write_policy(input logic [POLICY_W-1:0] policy);
    cfg_we <= 1'b1;
    cfg_wdata <= policy;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.policy = policy;
  endtask

  // Most requests are well formed: allocations of 1 to MEM_UNITS units and frees of live blocks.
  function automatic request_t random_request();
    request_t r;
    int live[$];
    int roll;
    r.mode = MODE_ALLOC;
    r.alloc_size = SIZE_W'($urandom);
    r.block_address = ADDR_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 48) begin
      roll = $urandom_range(99);
      if (roll < 70) r.alloc_size = SIZE_W'($urandom_range(1, 8));
      else if (roll < 92) r.alloc_size = SIZE_W'($urandom_range(9, MEM_UNITS));
    end else begin
      r.mode = MODE_FREE;
      for (int k = 0; k < MEM_UNITS; k++) begin
        if (shadow.starts[k] && shadow.used[k]) live.push_back(k);
      end
      if (roll < 88 && live.size() != 0) begin
        r.block_address = ADDR_W'(live[$urandom_range(live.size() - 1)]);
      end
    end
    return r;
  endfunction

  initial begin
    request_t r;
    int ph;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    request_chan.valid = 1'b0;
    request_chan.mode = MODE_ALLOC;
    request_chan.alloc_size = '0;
    request_chan.block_address = '0;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_policy(POLICY_FIRST);

    send_request(MODE_ALLOC, 7'd0, 6'd63);
    send_request(MODE_ALLOC, 7'd65, 6'd0);
    send_request(MODE_ALLOC, 7'd127, 6'd63);
    send_request(MODE_FREE, 7'd127, 6'd0);
    send_request(MODE_ALLOC, 7'd64, 6'd42);
    send_request(MODE_ALLOC, 7'd1, 6'd0);
    send_request(MODE_FREE, 7'd0, 6'd63);
    send_request(MODE_FREE, 7'd0, 6'd0);
    send_request(MODE_ALLOC, 7'd20, 6'd0);
    send_request(MODE_ALLOC, 7'd2, 6'd0);
    send_request(MODE_ALLOC, 7'd3, 6'd0);
    send_request(MODE_ALLOC, 7'd2, 6'd0);
    send_request(MODE_FREE, 7'd0, 6'd0);
    send_request(MODE_FREE, 7'd0, 6'd0);
    send_request(MODE_FREE, 7'd0, 6'd22);
    send_request(MODE_ALLOC, 7'd1, 6'd0);
    drain_results();
    write_policy(POLICY_BEST);
    send_request(MODE_ALLOC, 7'd3, 6'd0);
    send_request(MODE_ALLOC, 7'd19, 6'd0);
    drain_results();
    write_policy(POLICY_WORST);
    send_request(MODE_ALLOC, 7'd5, 6'd0);
    send_request(MODE_ALLOC, 7'd38, 6'd0);
    drain_results();
    write_policy(POLICY_WORST_ALT);
    send_request(MODE_ALLOC, 7'd4, 6'd0);
    send_request(MODE_FREE, 7'd0, 6'd63);
    send_request(MODE_FREE, 7'd0, 6'd20);

    for (ph = 0; ph < 12; ph++) begin
      drain_results();
      send_idle_pct = SEND_IDLE[ph / 4];
      recv_idle_pct = RECV_IDLE[ph / 4];
      write_policy(PHASE_POLICY[ph % 4]);
      repeat (PHASE_ITEMS) begin
        r = random_request();
        send_request(r.mode, r.alloc_size, r.block_address);
      end
    end

    drain_results();
    repeat (2 * MEM_UNITS + 8) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(25_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
